[hw/rtl/qph_pkg.sv]
`default_nettype none

package qph_pkg;

    localparam int POS_OUT_W  = 32;
    localparam int SPEED_W    = 10;
    localparam int OFFSET_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SPEED_W-1:0]  HOME_SPEED_RST  = 10'd192;
    localparam logic [OFFSET_W-1:0] HOME_OFFSET_RST = 16'd44;

    localparam logic [CFG_IDX_W-1:0] CFG_HOME_SPEED  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_OFFSET = 1'd1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_HOME  = 2'd1,
        FUNC_DRIVE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_COAST = 2'd0,
        MODE_CW    = 2'd1,
        MODE_CCW   = 2'd2,
        MODE_BRAKE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STEP_IDLE = 3'd0,
        STEP_1    = 3'd1,
        STEP_2    = 3'd2,
        STEP_3    = 3'd3,
        STEP_4    = 3'd4,
        STEP_5    = 3'd5
    } step_t;

    typedef struct packed {
        logic [1:0]         func;
        logic               enc_a;
        logic               enc_b;
        logic               hall_outside;
        logic [1:0]         drive_cmd;
        logic [SPEED_W-1:0] speed;
    } in_item_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] position;
        mode_t                drive_mode;
        logic [SPEED_W-1:0]   duty;
        logic                 homing_busy;
        logic                 homed;
        logic                 quad_error;
    } res_item_t;

endpackage

`default_nettype wire

[hw/rtl/qph_if.sv]
`default_nettype none

interface qph_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       enc_a;
    logic       enc_b;
    logic       hall_outside;
    logic [1:0] drive_cmd;
    logic [9:0] speed;

    modport source (
        output valid, func, enc_a, enc_b, hall_outside, drive_cmd, speed,
        input  ready
    );
    modport sink (
        input  valid, func, enc_a, enc_b, hall_outside, drive_cmd, speed,
        output ready
    );
endinterface

interface qph_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] position;
    logic [1:0]  drive_mode;
    logic [9:0]  duty;
    logic        homing_busy;
    logic        homed;
    logic        quad_error;

    modport source (
        output valid, position, drive_mode, duty, homing_busy, homed, quad_error,
        input  ready
    );
    modport sink (
        input  valid, position, drive_mode, duty, homing_busy, homed, quad_error,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/quadrature_position_homing.sv]
// quadrature_position_homing
//
// in_ch carries one item per handshake (valid and ready high at a clock edge):
// a tick sample, a start-homing request or a drive command, always with the
// encoder and hall levels. out_ch returns exactly one result item per input
// item, in order: position, drive mode, duty and the homing/error flags.
// cfg_we/cfg_index/cfg_data write home_speed (index 0) and home_offset
// (index 1).
// An item is registered at the input and, once the output side has room,
// processed against the encoder and homing state into the output register,
// from which the result is taken. One item per cycle is taken for as long
// as the receiver keeps up; the state update is the combinational decode,
// edge-sum and position adjust path.
// When the receiver stalls, an output register plus a skid entry absorb two
// results; the input register holds a third, then in_ch.ready drops.
// rst_n (asynchronous, active low) clears the position, homing sequence,
// drive mode, duty and flags, sets home_speed to 192 and home_offset to 44,
// and empties the pipeline.
`default_nettype none

module quadrature_position_homing #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [qph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qph_pkg::CFG_DATA_W-1:0] cfg_data,
    qph_in_if.sink                              in_ch,
    qph_out_if.source                           out_ch
);

    localparam int SUM_W = COUNT_WIDTH + 2;

    // configuration
    logic [qph_pkg::SPEED_W-1:0]         home_speed_reg;
    logic signed [qph_pkg::OFFSET_W-1:0] home_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_speed_reg  <= qph_pkg::HOME_SPEED_RST;
            home_offset_reg <= qph_pkg::HOME_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qph_pkg::CFG_HOME_SPEED:
                    home_speed_reg <= cfg_data[qph_pkg::SPEED_W-1:0];
                qph_pkg::CFG_HOME_OFFSET:
                    home_offset_reg <= cfg_data[qph_pkg::OFFSET_W-1:0];
                default:
                    home_speed_reg <= home_speed_reg;
            endcase
        end
    end

    // input register
    logic              a_vld_reg;
    qph_pkg::in_item_t a_data_reg;
    logic              push;
    logic              pop;
    logic              in_take;
    logic              out_vld_reg;
    logic              skid_vld_reg;

    assign in_ch.ready = !a_vld_reg || push;
    assign in_take     = in_ch.valid && in_ch.ready;
    assign pop         = out_vld_reg && out_ch.ready;
    assign push        = a_vld_reg && (!skid_vld_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            a_vld_reg <= 1'b1;
        end
        else if (push)
        begin
            a_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_data_reg.func         <= in_ch.func;
            a_data_reg.enc_a        <= in_ch.enc_a;
            a_data_reg.enc_b        <= in_ch.enc_b;
            a_data_reg.hall_outside <= in_ch.hall_outside;
            a_data_reg.drive_cmd    <= in_ch.drive_cmd;
            a_data_reg.speed        <= in_ch.speed;
        end
    end

    // block state
    logic [COUNT_WIDTH-1:0]      pos_reg;
    logic [COUNT_WIDTH-1:0]      pos_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;
    qph_pkg::step_t              step_reg;
    qph_pkg::step_t              step_next;
    qph_pkg::mode_t              mode_reg;
    qph_pkg::mode_t              mode_next;
    logic [qph_pkg::SPEED_W-1:0] duty_reg;
    logic [qph_pkg::SPEED_W-1:0] duty_next;
    logic                        last_a_reg;
    logic                        last_b_reg;
    logic                        homed_reg;
    logic                        homed_next;

    qph_pkg::func_t func_w;
    logic           hall_w;
    logic           ch_a;
    logic           ch_b;
    logic           qerr;
    logic           add_edge;
    logic           finish;

    logic [COUNT_WIDTH-1:0]      pos_dec;
    logic signed [SUM_W-1:0]     edge_val;
    logic signed [SUM_W-1:0]     sum_add;
    logic                        round_up;
    logic signed [SUM_W-1:0]     quarter;
    logic [COUNT_WIDTH-1:0]      off_ext;
    logic [COUNT_WIDTH-1:0]      pos_fin;
    logic signed [63:0]          pos_wide;

    assign func_w = qph_pkg::func_t'(a_data_reg.func);
    assign hall_w = a_data_reg.hall_outside;
    assign ch_a   = a_data_reg.enc_a != last_a_reg;
    assign ch_b   = a_data_reg.enc_b != last_b_reg;
    assign qerr   = ch_a && ch_b;

    // x4 decode
    always_comb
    begin
        pos_dec = pos_reg;
        if (ch_a && !ch_b)
        begin
            pos_dec = (a_data_reg.enc_a != a_data_reg.enc_b)
                    ? pos_reg + COUNT_WIDTH'(1) : pos_reg - COUNT_WIDTH'(1);
        end
        else if (ch_b && !ch_a)
        begin
            pos_dec = (a_data_reg.enc_a == a_data_reg.enc_b)
                    ? pos_reg + COUNT_WIDTH'(1) : pos_reg - COUNT_WIDTH'(1);
        end
    end

    // edge sum and average, truncated toward zero
    assign edge_val = SUM_W'(signed'(pos_dec));
    assign sum_add  = sum_reg + edge_val;
    assign round_up = sum_add[SUM_W-1] && (sum_add[1:0] != 2'b00);
    assign quarter  = sum_add >>> 2;
    assign off_ext  = COUNT_WIDTH'(home_offset_reg);
    assign pos_fin  = pos_dec - quarter[COUNT_WIDTH-1:0] - COUNT_WIDTH'(round_up) + off_ext;

    // homing sequencer: next step
    always_comb
    begin
        step_next = step_reg;
        case (func_w)
            qph_pkg::FUNC_TICK:
            begin
                case (step_reg)
                    qph_pkg::STEP_5: if (!hall_w) step_next = qph_pkg::STEP_4;
                    qph_pkg::STEP_4: if (hall_w)  step_next = qph_pkg::STEP_3;
                    qph_pkg::STEP_3: if (!hall_w) step_next = qph_pkg::STEP_2;
                    qph_pkg::STEP_2: if (hall_w)  step_next = qph_pkg::STEP_1;
                    qph_pkg::STEP_1: if (!hall_w) step_next = qph_pkg::STEP_IDLE;
                    default:         step_next = step_reg;
                endcase
            end
            qph_pkg::FUNC_HOME:
                step_next = hall_w ? qph_pkg::STEP_5 : qph_pkg::STEP_4;
            default:
                step_next = step_reg;
        endcase
    end

    // homing sequencer and drive: outputs
    always_comb
    begin
        add_edge   = 1'b0;
        finish     = 1'b0;
        mode_next  = mode_reg;
        duty_next  = duty_reg;
        sum_next   = sum_reg;
        case (func_w)
            qph_pkg::FUNC_TICK:
            begin
                case (step_reg)
                    qph_pkg::STEP_5:
                        if (!hall_w) mode_next = qph_pkg::MODE_CW;
                    qph_pkg::STEP_4, qph_pkg::STEP_2:
                        if (hall_w)
                        begin
                            add_edge  = 1'b1;
                            mode_next = qph_pkg::MODE_CCW;
                        end
                    qph_pkg::STEP_3:
                        if (!hall_w)
                        begin
                            add_edge  = 1'b1;
                            mode_next = qph_pkg::MODE_CW;
                        end
                    qph_pkg::STEP_1:
                        if (!hall_w)
                        begin
                            add_edge  = 1'b1;
                            finish    = 1'b1;
                            mode_next = qph_pkg::MODE_COAST;
                            duty_next = '0;
                        end
                    default:
                        mode_next = mode_reg;
                endcase
                if (add_edge)
                begin
                    sum_next = sum_add;
                end
            end
            qph_pkg::FUNC_HOME:
            begin
                mode_next = hall_w ? qph_pkg::MODE_CCW : qph_pkg::MODE_CW;
                duty_next = home_speed_reg;
                sum_next  = '0;
            end
            qph_pkg::FUNC_DRIVE:
            begin
                mode_next = qph_pkg::mode_t'(a_data_reg.drive_cmd);
                duty_next = (a_data_reg.drive_cmd == qph_pkg::MODE_COAST)
                          ? '0 : a_data_reg.speed;
            end
            default:
                mode_next = mode_reg;
        endcase
        pos_next   = finish ? pos_fin : pos_dec;
        homed_next = homed_reg || finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            step_reg   <= qph_pkg::STEP_IDLE;
            mode_reg   <= qph_pkg::MODE_COAST;
            duty_reg   <= '0;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
            homed_reg  <= 1'b0;
        end
        else if (push)
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            step_reg   <= step_next;
            mode_reg   <= mode_next;
            duty_reg   <= duty_next;
            last_a_reg <= a_data_reg.enc_a;
            last_b_reg <= a_data_reg.enc_b;
            homed_reg  <= homed_next;
        end
    end

    // result item
    qph_pkg::res_item_t res_w;

    assign pos_wide = 64'(signed'(pos_next));

    always_comb
    begin
        res_w.position    = pos_wide[qph_pkg::POS_OUT_W-1:0];
        res_w.drive_mode  = mode_next;
        res_w.duty        = duty_next;
        res_w.homing_busy = step_next != qph_pkg::STEP_IDLE;
        res_w.homed       = homed_next;
        res_w.quad_error  = qerr;
    end

    // output register with skid entry
    qph_pkg::res_item_t out_data_reg;
    qph_pkg::res_item_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_vld_reg || pop)
            begin
                out_vld_reg <= skid_vld_reg || push;
            end
            if (skid_vld_reg)
            begin
                skid_vld_reg <= !pop || push;
            end
            else
            begin
                skid_vld_reg <= out_vld_reg && !pop && push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
            if (push)
            begin
                skid_data_reg <= res_w;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || pop)
            begin
                out_data_reg <= res_w;
            end
            else
            begin
                skid_data_reg <= res_w;
            end
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.position    = out_data_reg.position;
    assign out_ch.drive_mode  = out_data_reg.drive_mode;
    assign out_ch.duty        = out_data_reg.duty;
    assign out_ch.homing_busy = out_data_reg.homing_busy;
    assign out_ch.homed       = out_data_reg.homed;
    assign out_ch.quad_error  = out_data_reg.quad_error;

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held without output entry");

    a_home_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        push && func_w == qph_pkg::FUNC_HOME |=> sum_reg == '0)
        else $error("edge sum not cleared on start homing");

    a_finish_ends: assert property (@(posedge clk) disable iff (!rst_n)
        push && finish |=> step_reg == qph_pkg::STEP_IDLE && homed_reg
            && mode_reg == qph_pkg::MODE_COAST && duty_reg == '0)
        else $error("homing end did not coast and set homed");

    a_homed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(homed_reg))
        else $error("homed flag dropped");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS    = 1250;
    localparam int CYCLE_CAP  = 200000;
    localparam int PHASE_LEN  = 210;
    localparam int QUIET_FROM = 520;
    localparam int QUIET_TO   = 780;
    localparam int HOLD_AT    = 950;
    localparam int MAX_PRINTS = 40;

    class homing_tracker;
        logic [qph_pkg::POS_OUT_W-1:0]       count;
        qph_pkg::step_t                      seq_step;
        longint                              edge_total;
        logic                                prev_a;
        logic                                prev_b;
        qph_pkg::mode_t                      mode;
        logic [qph_pkg::SPEED_W-1:0]         duty;
        logic                                homed;
        logic [qph_pkg::SPEED_W-1:0]         home_speed;
        logic signed [qph_pkg::OFFSET_W-1:0] home_offset;
        qph_pkg::res_item_t                  pending_readouts[$];
        int                                  faults;
        int                                  readouts_checked;
        int                                  homings_done;
        int                                  quad_errors;

        function new();
            count            = '0;
            seq_step         = qph_pkg::STEP_IDLE;
            edge_total       = 0;
            prev_a           = 1'b0;
            prev_b           = 1'b0;
            mode             = qph_pkg::MODE_COAST;
            duty             = '0;
            homed            = 1'b0;
            home_speed       = qph_pkg::HOME_SPEED_RST;
            home_offset      = qph_pkg::HOME_OFFSET_RST;
            faults           = 0;
            readouts_checked = 0;
            homings_done     = 0;
            quad_errors      = 0;
        endfunction

        task report(input string msg);
            faults++;
            if (faults <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void set_cfg(input logic [qph_pkg::CFG_IDX_W-1:0] idx,
                              input logic [qph_pkg::CFG_DATA_W-1:0] data);
            if (idx == qph_pkg::CFG_HOME_SPEED)
                home_speed = data[qph_pkg::SPEED_W-1:0];
            else
                home_offset = data;
        endfunction

        function void add_edge();
            edge_total += longint'($signed(count));
        endfunction

        function void finish_homing();
            longint     avg;
            logic [63:0] adj;
            // signed division truncates toward zero
            avg = edge_total / 4;
            adj = avg - longint'(home_offset);
            count = count - adj[qph_pkg::POS_OUT_W-1:0];
            homed = 1'b1;
            homings_done++;
        endfunction

        function void hall_tick(input logic outside);
            if (outside)
            begin
                if (seq_step == qph_pkg::STEP_4 || seq_step == qph_pkg::STEP_2)
                begin
                    add_edge();
                    mode = qph_pkg::MODE_CCW;
                    seq_step = qph_pkg::step_t'(seq_step - 3'd1);
                end
            end
            else if (seq_step == qph_pkg::STEP_5)
            begin
                mode = qph_pkg::MODE_CW;
                seq_step = qph_pkg::STEP_4;
            end
            else if (seq_step == qph_pkg::STEP_3)
            begin
                add_edge();
                mode = qph_pkg::MODE_CW;
                seq_step = qph_pkg::STEP_2;
            end
            else if (seq_step == qph_pkg::STEP_1)
            begin
                add_edge();
                mode = qph_pkg::MODE_COAST;
                duty = '0;
                seq_step = qph_pkg::STEP_IDLE;
                finish_homing();
            end
        endfunction

        function void take_sample(input qph_pkg::in_item_t it);
            logic               qerr;
            logic               ca;
            logic               cb;
            qph_pkg::res_item_t exp;
            qerr = 1'b0;
            ca = (it.enc_a != prev_a);
            cb = (it.enc_b != prev_b);
            if (ca && cb)
                qerr = 1'b1;
            else if (ca)
                count = (it.enc_a != it.enc_b) ? count + 1 : count - 1;
            else if (cb)
                count = (it.enc_a == it.enc_b) ? count + 1 : count - 1;
            prev_a = it.enc_a;
            prev_b = it.enc_b;
            case (it.func)
                qph_pkg::FUNC_TICK:
                    hall_tick(it.hall_outside);
                qph_pkg::FUNC_HOME:
                begin
                    mode = it.hall_outside ? qph_pkg::MODE_CCW : qph_pkg::MODE_CW;
                    seq_step = it.hall_outside ? qph_pkg::STEP_5 : qph_pkg::STEP_4;
                    duty = home_speed;
                    edge_total = 0;
                end
                qph_pkg::FUNC_DRIVE:
                begin
                    mode = qph_pkg::mode_t'(it.drive_cmd);
                    duty = (mode == qph_pkg::MODE_COAST) ? '0 : it.speed;
                end
                default:
                    ;
            endcase
            if (qerr)
                quad_errors++;
            exp.position    = count;
            exp.drive_mode  = mode;
            exp.duty        = duty;
            exp.homing_busy = (seq_step != qph_pkg::STEP_IDLE);
            exp.homed       = homed;
            exp.quad_error  = qerr;
            pending_readouts.push_back(exp);
        endfunction

        task check_readout(input qph_pkg::res_item_t got);
            qph_pkg::res_item_t exp;
            readouts_checked++;
            if (pending_readouts.size() == 0)
            begin
                report($sformatf("result with nothing pending, position %0d",
                                 $signed(got.position)));
                return;
            end
            exp = pending_readouts.pop_front();
            if (got.position !== exp.position)
                report($sformatf("position got %0d want %0d",
                                 $signed(got.position), $signed(exp.position)));
            if (got.drive_mode !== exp.drive_mode)
                report($sformatf("drive_mode got %0d want %0d",
                                 got.drive_mode, exp.drive_mode));
            if (got.duty !== exp.duty)
                report($sformatf("duty got %0d want %0d", got.duty, exp.duty));
            if (got.homing_busy !== exp.homing_busy)
                report($sformatf("homing_busy got %b want %b",
                                 got.homing_busy, exp.homing_busy));
            if (got.homed !== exp.homed)
                report($sformatf("homed got %b want %b", got.homed, exp.homed));
            if (got.quad_error !== exp.quad_error)
                report($sformatf("quad_error got %b want %b",
                                 got.quad_error, exp.quad_error));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [qph_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [qph_pkg::CFG_DATA_W-1:0] cfg_data;

    qph_in_if  in_ch ();
    qph_out_if out_ch ();

    quadrature_position_homing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    homing_tracker trk = new();

    bit   idle_on;
    int   n_sent;
    int   cycles = 0;
    logic cur_a;
    logic cur_b;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("quadrature_position_homing verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_ch.ready <= rst_n && (!idle_on || ($urandom_range(99) >= 9));

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            trk.check_readout(qph_pkg::res_item_t'{out_ch.position,
                                                   qph_pkg::mode_t'(out_ch.drive_mode),
                                                   out_ch.duty, out_ch.homing_busy,
                                                   out_ch.homed, out_ch.quad_error});
    end

    task automatic send_item(input qph_pkg::in_item_t it);
        while (idle_on && $urandom_range(99) < 9)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.func         <= it.func;
        in_ch.enc_a        <= it.enc_a;
        in_ch.enc_b        <= it.enc_b;
        in_ch.hall_outside <= it.hall_outside;
        in_ch.drive_cmd    <= it.drive_cmd;
        in_ch.speed        <= it.speed;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        trk.take_sample(it);
        n_sent++;
        cur_a = it.enc_a;
        cur_b = it.enc_b;
    endtask

    task automatic send_fields(input qph_pkg::func_t f, input logic a, input logic b,
                               input logic hall, input qph_pkg::mode_t cmd,
                               input logic [qph_pkg::SPEED_W-1:0] spd);
        qph_pkg::in_item_t it;
        it.func         = f;
        it.enc_a        = a;
        it.enc_b        = b;
        it.hall_outside = hall;
        it.drive_cmd    = cmd;
        it.speed        = spd;
        send_item(it);
    endtask

    // gray-code walk with a bias, the odd double change, or fully wild levels
    function automatic logic [1:0] next_levels(input bit fwd, input bit wild);
        int   r;
        logic a;
        logic b;
        a = cur_a;
        b = cur_b;
        r = $urandom_range(99);
        if (wild)
        begin
            a = 1'($urandom_range(1));
            b = 1'($urandom_range(1));
        end
        else if (r < 3)
        begin
            a = !a;
            b = !b;
        end
        else if (r >= 38)
        begin
            if ((r < 83) == fwd)
            begin
                if (a == b)
                    a = !a;
                else
                    b = !b;
            end
            else
            begin
                if (a == b)
                    b = !b;
                else
                    a = !a;
            end
        end
        return {a, b};
    endfunction

    task automatic send_random(input qph_pkg::func_t f, input logic hall, input bit fwd,
                               input bit wild);
        logic [1:0]        ab;
        qph_pkg::in_item_t it;
        ab              = next_levels(fwd, wild);
        it.func         = f;
        it.enc_a        = ab[1];
        it.enc_b        = ab[0];
        it.hall_outside = hall;
        it.drive_cmd    = 2'($urandom_range(3));
        it.speed        = 10'($urandom_range(1023));
        send_item(it);
    endtask

    task automatic run_homing();
        int   guard;
        int   r;
        bit   fwd;
        logic need;
        fwd = 1'($urandom_range(1));
        send_random(qph_pkg::FUNC_HOME, 1'($urandom_range(1)), fwd, 1'b0);
        guard = 0;
        while (trk.seq_step != qph_pkg::STEP_IDLE && guard < 80)
        begin
            r = $urandom_range(99);
            need = (trk.seq_step == qph_pkg::STEP_4 || trk.seq_step == qph_pkg::STEP_2);
            if ($urandom_range(9) == 0)
                fwd = !fwd;
            if (r < 3)
                send_random(qph_pkg::FUNC_HOME, 1'($urandom_range(1)), fwd, 1'b0);
            else if (r < 8)
                send_random(qph_pkg::FUNC_DRIVE, 1'($urandom_range(1)), fwd, 1'b0);
            else if (r < 11)
                send_random(qph_pkg::FUNC_NONE, 1'($urandom_range(1)), fwd, 1'b0);
            else
                send_random(qph_pkg::FUNC_TICK, ($urandom_range(99) < 40) ? need : !need,
                            fwd, 1'b0);
            guard++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (trk.pending_readouts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [qph_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qph_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        trk.set_cfg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int k);
        logic [qph_pkg::CFG_DATA_W-1:0] spd;
        logic [qph_pkg::CFG_DATA_W-1:0] off;
        case (k)
            0:
            begin
                spd = 16'd1023;
                off = 16'h7FFF;
            end
            1:
            begin
                spd = 16'd0;
                off = 16'h8000;
            end
            2:
            begin
                spd = 16'd1;
                off = 16'hFFFF;
            end
            3:
            begin
                spd = 16'($urandom_range(1023));
                off = 16'h0000;
            end
            default:
            begin
                spd = 16'($urandom_range(1023));
                off = 16'($urandom_range(16'hFFFF));
            end
        endcase
        write_cfg(qph_pkg::CFG_HOME_OFFSET, off);
        write_cfg(qph_pkg::CFG_HOME_SPEED, spd);
    endtask

    initial
    begin
        int n_cfg;
        int next_cfg;
        int burst;
        bit held;
        in_ch.valid        = 1'b0;
        in_ch.func         = qph_pkg::FUNC_TICK;
        in_ch.enc_a        = 1'b0;
        in_ch.enc_b        = 1'b0;
        in_ch.hall_outside = 1'b0;
        in_ch.drive_cmd    = qph_pkg::MODE_COAST;
        in_ch.speed        = '0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        rst_n              = 1'b0;
        idle_on            = 1'b1;
        cur_a              = 1'b0;
        cur_b              = 1'b0;
        n_sent             = 0;
        held               = 1'b0;
        n_cfg              = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drive modes, duty extremes, single and double line changes
        send_fields(qph_pkg::FUNC_TICK,  1'b0, 1'b0, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_DRIVE, 1'b0, 1'b0, 1'b0, qph_pkg::MODE_CW,    10'd1023);
        send_fields(qph_pkg::FUNC_DRIVE, 1'b0, 1'b0, 1'b1, qph_pkg::MODE_CCW,   10'd0);
        send_fields(qph_pkg::FUNC_DRIVE, 1'b0, 1'b0, 1'b0, qph_pkg::MODE_BRAKE, 10'd1023);
        send_fields(qph_pkg::FUNC_DRIVE, 1'b0, 1'b0, 1'b0, qph_pkg::MODE_COAST, 10'd1023);
        send_fields(qph_pkg::FUNC_NONE,  1'b1, 1'b0, 1'b1, qph_pkg::MODE_BRAKE, 10'd682);
        send_fields(qph_pkg::FUNC_TICK,  1'b1, 1'b1, 1'b1, qph_pkg::MODE_COAST, 10'd341);
        send_fields(qph_pkg::FUNC_TICK,  1'b0, 1'b1, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b1, 1'b0, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_NONE,  1'b0, 1'b1, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        // full homing run moving backwards so the edge sum goes negative
        send_fields(qph_pkg::FUNC_HOME,  1'b1, 1'b1, 1'b1, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b1, 1'b0, 1'b1, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b0, 1'b0, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b0, 1'b1, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b1, 1'b1, 1'b1, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b1, 1'b0, 1'b1, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b0, 1'b0, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_DRIVE, 1'b0, 1'b0, 1'b0, qph_pkg::MODE_BRAKE, 10'd512);
        send_fields(qph_pkg::FUNC_TICK,  1'b0, 1'b1, 1'b1, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_TICK,  1'b1, 1'b1, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        // start inside, then restart from outside while still homing
        send_fields(qph_pkg::FUNC_HOME,  1'b1, 1'b1, 1'b0, qph_pkg::MODE_COAST, 10'd0);
        send_fields(qph_pkg::FUNC_HOME,  1'b1, 1'b1, 1'b1, qph_pkg::MODE_CW,    10'd1023);
        send_fields(qph_pkg::FUNC_DRIVE, 1'b1, 1'b1, 1'b0, qph_pkg::MODE_COAST, 10'd1023);
        send_fields(qph_pkg::FUNC_NONE,  1'b1, 1'b1, 1'b1, qph_pkg::MODE_CCW,   10'd1023);

        next_cfg = n_sent;
        while (n_sent < N_ITEMS)
        begin
            if (n_sent >= next_cfg)
            begin
                drain();
                apply_setting(n_cfg);
                n_cfg++;
                next_cfg = n_sent + PHASE_LEN;
            end
            idle_on = !(n_sent >= QUIET_FROM && n_sent < QUIET_TO);
            if (!held && n_sent >= HOLD_AT)
            begin
                drain();
                held = 1'b1;
            end
            if ($urandom_range(99) < 70)
                run_homing();
            else
            begin
                burst = $urandom_range(1, 10);
                repeat (burst)
                    send_random(qph_pkg::func_t'($urandom_range(3)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), $urandom_range(99) < 25);
            end
        end
        drain();

        $display("sent %0d items, checked %0d results, %0d homing runs completed",
                 n_sent, trk.readouts_checked, trk.homings_done);
        $display("%0d encoder errors predicted over %0d register settings plus reset values",
                 trk.quad_errors, n_cfg);
        if (trk.faults == 0 && trk.pending_readouts.size() == 0)
            $display("quadrature_position_homing verification clean");
        else
            $display("quadrature_position_homing verification failed");
        $finish;
    end

endmodule
